/* src/rrs_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, register indexes and pipeline types of the rounded-rectangle shadow block.
package rrs_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int MAX_SHADOW  = 256;
   localparam int MAX_OFFSET  = 1024;
   localparam int MAX_OPACITY = 100;

   localparam int PIX_W      = 13;
   localparam int DIM_W      = 13;
   localparam int RAD_W      = 12;
   localparam int SIZE_W     = 9;
   localparam int OFS_W      = 12;
   localparam int OP_W       = 7;
   localparam int ALPHA_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam int SQ_IN_W  = 43;
   localparam int SQ_OUT_W = 22;
   localparam int SQ_STEPS = 22;
   localparam int SQ_R_W   = 45;

   localparam int DV_NUM_W = 25;
   localparam int DV_Q_W   = 17;
   localparam int DV_STEPS = 17;

   localparam int INNER_W = 14;

   localparam int FRONT_LAT  = 6;
   localparam int SMOOTH_LAT = 3;
   localparam int PIPE_LAT   = FRONT_LAT + SQ_STEPS + 1 + DV_STEPS + SMOOTH_LAT;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWNER_WIDTH  = 3'd0,
      CSR_OWNER_HEIGHT = 3'd1,
      CSR_CORNER       = 3'd2,
      CSR_SHADOW_SIZE  = 3'd3,
      CSR_SHADOW_DX    = 3'd4,
      CSR_SHADOW_DY    = 3'd5,
      CSR_OPACITY      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                      zero;
      logic signed [INNER_W-1:0] inner;
   } sq_side_type;

endpackage

/* src/rrs_isqrt.sv */
`timescale 1ns / 1ps
// Pipelined truncated integer square root, one result bit per stage.
module rrs_isqrt import rrs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [SQ_IN_W-1:0]  in_val,
   input  sq_side_type         in_side,
   output logic                out_valid,
   output logic [SQ_OUT_W-1:0] out_root,
   output sq_side_type         out_side
);

   logic [SQ_STEPS-1:0] vld_ff;
   logic [SQ_R_W-1:0]   rem_ff  [SQ_STEPS];
   logic [SQ_R_W-1:0]   root_ff [SQ_STEPS];
   sq_side_type         side_ff [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      localparam logic [SQ_R_W-1:0] StepBit = SQ_R_W'(1) << (2 * (SQ_STEPS - 1 - k));
      logic              vld_i;
      logic [SQ_R_W-1:0] rem_i, root_i, trial, rem_in, root_in;
      sq_side_type       side_i;

      if (k == 0) begin : g_first
         assign vld_i  = in_valid;
         assign rem_i  = SQ_R_W'(in_val);
         assign root_i = '0;
         assign side_i = in_side;
      end else begin : g_next
         assign vld_i  = vld_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign root_i = root_ff[k-1];
         assign side_i = side_ff[k-1];
      end

      always_comb begin
         trial = root_i + StepBit;
         if (rem_i >= trial) begin
            rem_in  = rem_i - trial;
            root_in = (root_i >> 1) + StepBit;
         end else begin
            rem_in  = rem_i;
            root_in = root_i >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_i;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_i;
      end
   end

   assign out_valid = vld_ff[SQ_STEPS-1];
   assign out_root  = root_ff[SQ_STEPS-1][SQ_OUT_W-1:0];
   assign out_side  = side_ff[SQ_STEPS-1];

endmodule

/* src/rrs_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider that normalises the shadow distance, one quotient bit per stage.
module rrs_div import rrs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                in_zero,
   input  logic [DV_NUM_W-1:0] in_num,
   input  logic [SIZE_W-1:0]   divisor,
   output logic                out_valid,
   output logic                out_zero,
   output logic [DV_Q_W-1:0]   out_quot
);

   logic [DV_STEPS-1:0] vld_ff;
   logic [DV_STEPS-1:0] zero_ff;
   logic [DV_NUM_W-1:0] rem_ff [DV_STEPS];
   logic [DV_Q_W-1:0]   quot_ff [DV_STEPS];

   for (genvar k = 0; k < DV_STEPS; k++) begin : g_step
      localparam int Shift = DV_STEPS - 1 - k;
      logic                vld_i, zero_i, ge;
      logic [DV_NUM_W-1:0] rem_i, dsh, rem_in;
      logic [DV_Q_W-1:0]   quot_i, quot_in;

      if (k == 0) begin : g_first
         assign vld_i  = in_valid;
         assign zero_i = in_zero;
         assign rem_i  = in_num;
         assign quot_i = '0;
      end else begin : g_next
         assign vld_i  = vld_ff[k-1];
         assign zero_i = zero_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign quot_i = quot_ff[k-1];
      end

      always_comb begin
         dsh     = DV_NUM_W'(divisor) << Shift;
         ge      = rem_i >= dsh;
         rem_in  = ge ? rem_i - dsh : rem_i;
         quot_in = {quot_i[DV_Q_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_i;
         end
         zero_ff[k] <= zero_i;
         rem_ff[k]  <= rem_in;
         quot_ff[k] <= quot_in;
      end
   end

   assign out_valid = vld_ff[DV_STEPS-1];
   assign out_zero  = zero_ff[DV_STEPS-1];
   assign out_quot  = quot_ff[DV_STEPS-1];

endmodule

/* src/rrs_smooth.sv */
`timescale 1ns / 1ps
// Smoothstep falloff and rounding of the shadow alpha over three register stages.
module rrs_smooth import rrs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_zero,
   input  logic [DV_Q_W-1:0]  in_n,
   input  logic [ALPHA_W-1:0] peak_alpha,
   output logic               out_valid,
   output logic [ALPHA_W-1:0] out_alpha
);

   localparam int TT_W  = 32;
   localparam int KF_W  = DV_Q_W + 1;
   localparam int K_W   = KF_W + ALPHA_W;
   localparam int NUM_W = TT_W + K_W;
   localparam logic [KF_W-1:0]   THREE_ONE = KF_W'(3 * 65536);
   localparam logic [DV_Q_W-1:0] ONE_Q16   = DV_Q_W'(65536);
   localparam logic [NUM_W-1:0]  HALF_LSB  = NUM_W'(1) << 47;

   logic [DV_Q_W-1:0] t;
   logic [KF_W-1:0]   kf;
   logic [TT_W-1:0]   tt_in, tt_ff;
   logic [K_W-1:0]    k_in, k1_ff;
   logic [NUM_W-1:0]  num_in, num_ff, rnd;
   logic [ALPHA_W-1:0] alpha_in, alpha_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic z1_ff, z2_ff, f1_ff, f2_ff, full_in;

   always_comb begin
      t       = ONE_Q16 - in_n;
      full_in = (in_n == '0);
      kf      = THREE_ONE - {t, 1'b0};
      tt_in   = TT_W'(t[15:0]) * TT_W'(t[15:0]);
      k_in    = K_W'(peak_alpha) * K_W'(kf);
      num_in  = NUM_W'(tt_ff) * NUM_W'(k1_ff);
      rnd     = num_ff + HALF_LSB;
      if (z2_ff) begin
         alpha_in = '0;
      end else if (f2_ff) begin
         alpha_in = peak_alpha;
      end else begin
         alpha_in = rnd[55:48];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      tt_ff    <= tt_in;
      k1_ff    <= k_in;
      z1_ff    <= in_zero;
      f1_ff    <= full_in;
      num_ff   <= num_in;
      z2_ff    <= z1_ff;
      f2_ff    <= f1_ff;
      alpha_ff <= alpha_in;
   end

   assign out_valid = v3_ff;
   assign out_alpha = alpha_ff;

endmodule

/* src/rounded_rect_shadow_alpha_top.sv */
`timescale 1ns / 1ps
// Top level of the rounded-rectangle drop-shadow alpha pipeline.
//
//  Channel   Ports                                      Transfer
//  request   start, busy, req_pixel_x/y                 start high and busy low at a clock edge
//  result    rsp_valid, rsp_alpha                       rsp_valid high for one cycle, always taken
//  config    csr_valid/ready, csr_index, csr_wdata      csr_valid and csr_ready high at an edge
//
// One pixel is taken in every cycle outside reset; its alpha passes through six
// front stages, the 22-stage square root, one distance stage, the 17-stage
// divider and three smoothstep stages.
// Reset is synchronous and clears the CSRs and all valid bits; busy is high only in reset.
// The result side never stalls, so the pipeline always advances.
module rounded_rect_shadow_alpha_top import rrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [PIX_W-1:0]      req_pixel_x,
   input  logic [PIX_W-1:0]      req_pixel_y,
   output logic                  rsp_valid,
   output logic [ALPHA_W-1:0]    rsp_alpha,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LEFT_W  = OFS_W - 1;
   localparam int CANV_W  = 14;
   localparam int COORD_W = 16;
   localparam int Q_W     = 17;
   localparam int SQR_W   = 28;
   localparam int SUM_W   = 29;
   localparam int RR_W    = 40;
   localparam int S256_W  = SIZE_W + 8;
   localparam int OP255_W = 15;
   localparam int MA_P_W  = 28;
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam logic signed [OFS_W-1:0] OFS_HI = OFS_W'(MAX_OFFSET);
   localparam logic signed [OFS_W-1:0] OFS_LO = -OFS_W'(MAX_OFFSET);

   logic accept;
   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   logic [DIM_W-1:0]  owner_width_ff, owner_height_ff;
   logic [RAD_W-1:0]  corner_radius_ff;
   logic [SIZE_W-1:0] shadow_size_ff;
   logic [OFS_W-1:0]  shadow_dx_ff, shadow_dy_ff;
   logic [OP_W-1:0]   opacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_width_ff   <= '0;
         owner_height_ff  <= '0;
         corner_radius_ff <= '0;
         shadow_size_ff   <= '0;
         shadow_dx_ff     <= '0;
         shadow_dy_ff     <= '0;
         opacity_ff       <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_OWNER_WIDTH:  owner_width_ff   <= csr_wdata[DIM_W-1:0];
            CSR_OWNER_HEIGHT: owner_height_ff  <= csr_wdata[DIM_W-1:0];
            CSR_CORNER:       corner_radius_ff <= csr_wdata[RAD_W-1:0];
            CSR_SHADOW_SIZE:  shadow_size_ff   <= csr_wdata[SIZE_W-1:0];
            CSR_SHADOW_DX:    shadow_dx_ff     <= csr_wdata[OFS_W-1:0];
            CSR_SHADOW_DY:    shadow_dy_ff     <= csr_wdata[OFS_W-1:0];
            CSR_OPACITY:      opacity_ff       <= csr_wdata[OP_W-1:0];
            default: ;
         endcase
      end
   end

   // Derived geometry, first level.
   logic [DIM_W-1:0]        wa_in, ha_in, wa_ff, ha_ff;
   logic [SIZE_W-1:0]       sza_in, sza_ff;
   logic signed [OFS_W-1:0] dx_c, dy_c;
   logic [LEFT_W-1:0]       adx, ady;
   logic [LEFT_W-1:0]       lefta_in, topa_in, left2a_in, top2a_in;
   logic [LEFT_W-1:0]       lefta_ff, topa_ff, left2a_ff, top2a_ff;
   logic [CANV_W-1:0]       cwa_in, cha_in, cwa_ff, cha_ff;
   logic [OP_W-1:0]         opa_in, opa_ff;
   logic                    disa_in, disa_ff;

   always_comb begin
      wa_in  = (owner_width_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : owner_width_ff;
      ha_in  = (owner_height_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : owner_height_ff;
      sza_in = (shadow_size_ff > SIZE_W'(MAX_SHADOW)) ? SIZE_W'(MAX_SHADOW) : shadow_size_ff;
      dx_c   = $signed(shadow_dx_ff);
      if (dx_c > OFS_HI) begin
         dx_c = OFS_HI;
      end else if (dx_c < OFS_LO) begin
         dx_c = OFS_LO;
      end
      dy_c = $signed(shadow_dy_ff);
      if (dy_c > OFS_HI) begin
         dy_c = OFS_HI;
      end else if (dy_c < OFS_LO) begin
         dy_c = OFS_LO;
      end
      adx       = dx_c[OFS_W-1] ? LEFT_W'(-dx_c) : dx_c[LEFT_W-1:0];
      ady       = dy_c[OFS_W-1] ? LEFT_W'(-dy_c) : dy_c[LEFT_W-1:0];
      lefta_in  = LEFT_W'(sza_in) + (dx_c[OFS_W-1] ? adx : '0);
      topa_in   = LEFT_W'(sza_in) + (dy_c[OFS_W-1] ? ady : '0);
      left2a_in = LEFT_W'(sza_in) + (dx_c[OFS_W-1] ? '0 : adx);
      top2a_in  = LEFT_W'(sza_in) + (dy_c[OFS_W-1] ? '0 : ady);
      cwa_in    = CANV_W'(wa_in) + CANV_W'({sza_in, 1'b0}) + CANV_W'(adx);
      cha_in    = CANV_W'(ha_in) + CANV_W'({sza_in, 1'b0}) + CANV_W'(ady);
      opa_in    = (opacity_ff > OP_W'(MAX_OPACITY)) ? OP_W'(MAX_OPACITY) : opacity_ff;
      disa_in   = (wa_in == '0) || (ha_in == '0) || (sza_in == '0) || (opa_in == '0);
   end

   // Derived geometry, second and third levels.
   logic [RAD_W-1:0]   half_side, rb_in, rb_ff;
   logic [DIM_W-1:0]   wrb_in, hrb_in, wrb_ff, hrb_ff;
   logic [OP255_W-1:0] op255;
   logic [MA_P_W-1:0]  ma_prod;
   logic [ALPHA_W-1:0] mab_in, mab_ff;
   logic [S256_W-1:0]  s256_ff;
   logic [RR_W-1:0]    rrc_in, rrc_ff;

   always_comb begin
      half_side = RAD_W'(((wa_ff < ha_ff) ? wa_ff : ha_ff) >> 1);
      rb_in     = (corner_radius_ff < half_side) ? corner_radius_ff : half_side;
      wrb_in    = wa_ff - DIM_W'({rb_in, 1'b0});
      hrb_in    = ha_ff - DIM_W'({rb_in, 1'b0});
      op255     = (OP255_W'(opa_ff) << 8) - OP255_W'(opa_ff);
      ma_prod   = MA_P_W'(op255) * MA_P_W'(RECIP_100);
      mab_in    = ALPHA_W'(ma_prod >> RECIP_SHIFT);
      rrc_in    = RR_W'({rb_ff, 8'h01}) * RR_W'({rb_ff, 8'h01});
   end

   always_ff @(posedge clock) begin
      wa_ff     <= wa_in;
      ha_ff     <= ha_in;
      sza_ff    <= sza_in;
      lefta_ff  <= lefta_in;
      topa_ff   <= topa_in;
      left2a_ff <= left2a_in;
      top2a_ff  <= top2a_in;
      cwa_ff    <= cwa_in;
      cha_ff    <= cha_in;
      opa_ff    <= opa_in;
      disa_ff   <= disa_in;
      rb_ff     <= rb_in;
      wrb_ff    <= wrb_in;
      hrb_ff    <= hrb_in;
      mab_ff    <= mab_in;
      s256_ff   <= {sza_ff, 8'b0};
      rrc_ff    <= rrc_in;
   end

   // Front pipeline: coordinates, box excesses, squares and sums.
   logic                    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [PIX_W-1:0]        x1_ff, y1_ff;
   logic signed [COORD_W-1:0] p_in [4];
   logic signed [COORD_W-1:0] p_ff [4];
   logic signed [Q_W-1:0]   q_in [4];
   logic signed [Q_W-1:0]   q_ff [4];
   logic [SQR_W-1:0]        sq_in [4];
   logic [SQR_W-1:0]        sq_ff [4];
   logic signed [COORD_W-1:0] sx1, sy1, sx2, sy2;
   logic                    off_in, off2_ff, off3_ff, off4_ff, off5_ff;
   logic signed [Q_W-1:0]   qm;
   logic signed [INNER_W-1:0] inner_in, inner4_ff, inner5_ff;
   logic [SUM_W-1:0]        s1_in, s2_in, s1_ff, s2_ff;
   logic                    inside_in;
   sq_side_type             side_in, side6_ff;
   logic [SQ_IN_W-1:0]      sqv_in, sqv6_ff;

   always_comb begin
      sx1 = $signed({3'b0, x1_ff}) - $signed({5'b0, lefta_ff});
      sy1 = $signed({3'b0, y1_ff}) - $signed({5'b0, topa_ff});
      sx2 = $signed({3'b0, x1_ff}) - $signed({5'b0, left2a_ff});
      sy2 = $signed({3'b0, y1_ff}) - $signed({5'b0, top2a_ff});
      p_in[0] = {sx1[COORD_W-2:0], 1'b1};
      p_in[1] = {sy1[COORD_W-2:0], 1'b1};
      p_in[2] = {sx2[COORD_W-2:0], 1'b1};
      p_in[3] = {sy2[COORD_W-2:0], 1'b1};
      off_in  = (CANV_W'(x1_ff) >= cwa_ff) || (CANV_W'(y1_ff) >= cha_ff);
   end

   for (genvar i = 0; i < 4; i++) begin : g_axis
      logic signed [Q_W-1:0] diff, mag;
      logic [DIM_W-1:0]      dim, dimr;
      logic [INNER_W-1:0]    ox;
      always_comb begin
         dim  = (i % 2 == 0) ? wa_ff : ha_ff;
         dimr = (i % 2 == 0) ? wrb_ff : hrb_ff;
         diff = $signed({p_ff[i][COORD_W-1], p_ff[i]}) - $signed({4'b0, dim});
         mag  = diff[Q_W-1] ? -diff : diff;
         q_in[i] = mag - $signed({4'b0, dimr});
         ox   = q_ff[i][Q_W-1] ? '0 : q_ff[i][INNER_W-1:0];
         sq_in[i] = SQR_W'(ox) * SQR_W'(ox);
      end
   end

   always_comb begin
      qm        = (q_ff[2] > q_ff[3]) ? q_ff[2] : q_ff[3];
      inner_in  = qm[Q_W-1] ? qm[INNER_W-1:0] : '0;
      s1_in     = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]);
      s2_in     = SUM_W'(sq_ff[2]) + SUM_W'(sq_ff[3]);
      inside_in = {s1_ff, 14'b0} < SQ_IN_W'(rrc_ff);
      side_in.zero  = off5_ff || inside_in;
      side_in.inner = inner5_ff;
      sqv_in    = {s2_ff, 14'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
      x1_ff     <= req_pixel_x;
      y1_ff     <= req_pixel_y;
      p_ff      <= p_in;
      off2_ff   <= off_in;
      q_ff      <= q_in;
      off3_ff   <= off2_ff;
      sq_ff     <= sq_in;
      off4_ff   <= off3_ff;
      inner4_ff <= inner_in;
      s1_ff     <= s1_in;
      s2_ff     <= s2_in;
      off5_ff   <= off4_ff;
      inner5_ff <= inner4_ff;
      side6_ff  <= side_in;
      sqv6_ff   <= sqv_in;
   end

   logic                sq_valid;
   logic [SQ_OUT_W-1:0] sq_root;
   sq_side_type         sq_side;

   rrs_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_val    (sqv6_ff),
      .in_side   (side6_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Shadow distance and range checks.
   logic signed [DV_NUM_W-1:0] dd;
   logic                       beyond, dz_in, dz_ff, dv_ff;
   logic [DV_Q_W-1:0]          dpos;
   logic [DV_NUM_W-1:0]        dn_in, dn_ff;

   always_comb begin
      dd     = $signed(DV_NUM_W'(sq_root)) + (DV_NUM_W'(sq_side.inner) <<< 7)
               - $signed(DV_NUM_W'({rb_ff, 8'b0}));
      beyond = dd > $signed(DV_NUM_W'(s256_ff));
      dpos   = (!dd[DV_NUM_W-1] && (dd != '0)) ? dd[DV_Q_W-1:0] : '0;
      dn_in  = DV_NUM_W'({dpos, 8'b0});
      dz_in  = sq_side.zero || beyond || disa_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
      end else begin
         dv_ff <= sq_valid;
      end
      dz_ff <= dz_in;
      dn_ff <= dn_in;
   end

   logic              nv, nz;
   logic [DV_Q_W-1:0] nq;

   rrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_ff),
      .in_zero   (dz_ff),
      .in_num    (dn_ff),
      .divisor   (sza_ff),
      .out_valid (nv),
      .out_zero  (nz),
      .out_quot  (nq)
   );

   rrs_smooth u_smooth (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (nv),
      .in_zero    (nz),
      .in_n       (nq),
      .peak_alpha (mab_ff),
      .out_valid  (rsp_valid),
      .out_alpha  (rsp_alpha)
   );

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LAT rsp_valid)
      else $error("Accepted pixel produced no result after the pipeline latency.");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_LAT))
      else $error("Result produced without a matching accepted pixel.");

endmodule
